### design/hme_pkg.sv
package hme_pkg;

    localparam int TABLE_LEN = 24;
    localparam int DEF_CORDIC_STEPS = 16;

    // 2^40 / (2 pi): radians in Q24.24 to a 32-bit turn angle
    localparam logic [37:0] RAD_TO_TURN = 38'd174992710548;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [15:0] AMP_RESET = 16'd4096;
    localparam logic [15:0] RATE_RESET = 16'd256;
    localparam logic [15:0] PHASE_RESET = 16'd0;

    localparam logic [1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [1:0] REG_RATE = 2'd1;
    localparam logic [1:0] REG_PHASE = 2'd2;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } cordic_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h20000000;
            1: v = 32'h12E4051E;
            2: v = 32'h09FB385B;
            3: v = 32'h051111D4;
            4: v = 32'h028B0D43;
            5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;
            7: v = 32'h00517C55;
            8: v = 32'h0028BE53;
            9: v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### design/hme_angle.sv
module hme_angle (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          sample_time,
    input  logic [15:0]          angular_rate,
    input  logic [15:0]          start_phase,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hme_pkg::cordic_t     out_data
);

    logic [2:0]        vld_reg;
    logic [2:0]        adv;
    logic [47:0]       p_reg;
    logic [47:0]       p_next;
    logic [42:0]       ll_reg, lh_reg, hl_reg, hh_reg;
    logic [42:0]       ll_next, lh_next, hl_next, hh_next;
    logic [63:0]       sum;
    logic [31:0]       angle;
    logic              flip;
    logic [31:0]       folded;
    hme_pkg::cordic_t  data_reg;
    hme_pkg::cordic_t  data_next;

    assign adv[2] = !vld_reg[2] || !out_stall;
    assign adv[1] = !vld_reg[1] || adv[2];
    assign adv[0] = !vld_reg[0] || adv[1];
    assign in_stall = !adv[0];

    assign p_next = {32'b0, angular_rate} * {16'b0, sample_time};

    // split p * K into four partial products, 24x19 bits each
    assign ll_next = {19'b0, p_reg[23:0]} * {24'b0, hme_pkg::RAD_TO_TURN[18:0]};
    assign lh_next = {19'b0, p_reg[23:0]} * {24'b0, hme_pkg::RAD_TO_TURN[37:19]};
    assign hl_next = {19'b0, p_reg[47:24]} * {24'b0, hme_pkg::RAD_TO_TURN[18:0]};
    assign hh_next = {19'b0, p_reg[47:24]} * {24'b0, hme_pkg::RAD_TO_TURN[37:19]};

    always_comb
    begin
        sum = {21'b0, ll_reg} + ({21'b0, lh_reg} << 19) + ({21'b0, hl_reg} << 24)
            + ({21'b0, hh_reg} << 43);
        angle = sum[63:32] + {start_phase, 16'b0};
        // fold the left half plane by half a turn
        flip = angle[31] ^ angle[30];
        folded = {angle[31] ^ flip, angle[30:0]};
        data_next.x = hme_pkg::INV_GAIN_Q30;
        data_next.y = '0;
        data_next.z = {{2{folded[31]}}, folded};
        data_next.flip = flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p_reg <= p_next;
        end
        if (adv[1])
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (adv[2])
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data = data_reg;

endmodule

### design/hme_cordic.sv
module hme_cordic #(
    parameter int CORDIC_STEPS = hme_pkg::DEF_CORDIC_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  hme_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output hme_pkg::cordic_t out_data
);

    localparam int NSTAGE = (CORDIC_STEPS > hme_pkg::TABLE_LEN) ? hme_pkg::TABLE_LEN
                                                                : CORDIC_STEPS;

    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  adv;
    hme_pkg::cordic_t   stage_reg [NSTAGE];

    genvar g;
    generate
        for (g = 0; g < NSTAGE; g++)
        begin : gen_stage
            hme_pkg::cordic_t   src;
            hme_pkg::cordic_t   stage_next;
            logic               prev_valid;
            logic signed [33:0] dx, dy, da;

            if (g == 0)
            begin : gen_first
                assign src = in_data;
                assign prev_valid = in_valid;
            end
            else
            begin : gen_rest
                assign src = stage_reg[g-1];
                assign prev_valid = vld_reg[g-1];
            end

            if (g == NSTAGE - 1)
            begin : gen_last_adv
                assign adv[g] = !vld_reg[g] || !out_stall;
            end
            else
            begin : gen_mid_adv
                assign adv[g] = !vld_reg[g] || adv[g+1];
            end

            assign dx = src.y >>> g;
            assign dy = src.x >>> g;
            assign da = {2'b0, hme_pkg::atan_turn(g)};

            always_comb
            begin
                stage_next.flip = src.flip;
                if (!src.z[33])
                begin
                    stage_next.x = src.x - dx;
                    stage_next.y = src.y + dy;
                    stage_next.z = src.z - da;
                end
                else
                begin
                    stage_next.x = src.x + dx;
                    stage_next.y = src.y - dy;
                    stage_next.z = src.z + da;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else if (adv[g])
                begin
                    vld_reg[g] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[g])
                begin
                    stage_reg[g] <= stage_next;
                end
            end
        end
    endgenerate

    assign in_stall = !adv[0];
    assign out_valid = vld_reg[NSTAGE-1];
    assign out_data = stage_reg[NSTAGE-1];

endmodule

### design/hme_scale.sv
module hme_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hme_pkg::cordic_t     in_data,
    input  logic [15:0]          amplitude,
    input  logic [31:0]          amp_rate,
    input  logic [31:0]          rate_sq,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [16:0]   position,
    output logic signed [24:0]   speed,
    output logic signed [32:0]   accel
);

    logic [4:0]          vld_reg;
    logic [4:0]          adv;
    logic signed [33:0]  xf, yf;
    logic signed [31:0]  cos_reg, sin_reg, cos_next, sin_next;
    logic signed [48:0]  ac_reg, ac_next;
    logic signed [64:0]  aws_reg, aws_next;
    logic signed [48:0]  pos_sh, cos_sh;
    logic signed [64:0]  spd_sh;
    logic signed [24:0]  spd_pos;
    logic signed [16:0]  pos2_reg, pos3_reg, pos_reg;
    logic signed [24:0]  spd2_reg, spd3_reg, spd_reg;
    logic signed [29:0]  amp_cos_reg;
    logic signed [62:0]  prod_reg, prod_next;
    logic signed [62:0]  acc_sh;
    logic signed [32:0]  acc_pos;
    logic signed [32:0]  acc_reg;

    assign adv[4] = !vld_reg[4] || !out_stall;
    assign adv[3] = !vld_reg[3] || adv[4];
    assign adv[2] = !vld_reg[2] || adv[3];
    assign adv[1] = !vld_reg[1] || adv[2];
    assign adv[0] = !vld_reg[0] || adv[1];
    assign in_stall = !adv[0];

    // undo the half-turn fold, then clamp to the unit range
    always_comb
    begin
        xf = in_data.flip ? -in_data.x : in_data.x;
        yf = in_data.flip ? -in_data.y : in_data.y;
        if (xf > hme_pkg::ONE_Q30)
        begin
            cos_next = 32'(hme_pkg::ONE_Q30);
        end
        else if (xf < -hme_pkg::ONE_Q30)
        begin
            cos_next = 32'(-hme_pkg::ONE_Q30);
        end
        else
        begin
            cos_next = 32'(xf);
        end
        if (yf > hme_pkg::ONE_Q30)
        begin
            sin_next = 32'(hme_pkg::ONE_Q30);
        end
        else if (yf < -hme_pkg::ONE_Q30)
        begin
            sin_next = 32'(-hme_pkg::ONE_Q30);
        end
        else
        begin
            sin_next = 32'(yf);
        end
    end

    assign ac_next = $signed({33'b0, amplitude}) * 49'(cos_reg);
    assign aws_next = $signed({33'b0, amp_rate}) * 65'(sin_reg);

    assign pos_sh = (ac_reg + 49'sd536870912) >>> 30;
    assign cos_sh = (ac_reg + 49'sd131072) >>> 18;
    assign spd_sh = (aws_reg + 65'sd137438953472) >>> 38;
    assign spd_pos = 25'(spd_sh);

    assign prod_next = 63'(amp_cos_reg) * $signed({31'b0, rate_sq});
    assign acc_sh = (prod_reg + 63'sd134217728) >>> 28;
    assign acc_pos = 33'(acc_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
            if (adv[3])
            begin
                vld_reg[3] <= vld_reg[2];
            end
            if (adv[4])
            begin
                vld_reg[4] <= vld_reg[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (adv[1])
        begin
            ac_reg <= ac_next;
            aws_reg <= aws_next;
        end
        if (adv[2])
        begin
            pos2_reg <= 17'(pos_sh);
            spd2_reg <= -spd_pos;
            amp_cos_reg <= 30'(cos_sh);
        end
        if (adv[3])
        begin
            pos3_reg <= pos2_reg;
            spd3_reg <= spd2_reg;
            prod_reg <= prod_next;
        end
        if (adv[4])
        begin
            pos_reg <= pos3_reg;
            spd_reg <= spd3_reg;
            acc_reg <= -acc_pos;
        end
    end

    assign out_valid = vld_reg[4];
    assign position = pos_reg;
    assign speed = spd_reg;
    assign accel = acc_reg;

endmodule

### design/harmonic_motion_evaluator.sv
// Simple harmonic motion evaluator. Each sample_time request (Q16.16 seconds)
// returns position = A cos(theta), speed = -A w sin(theta) and
// accel = -A w^2 cos(theta), theta = w t + phase, sine and cosine from a
// pipelined CORDIC with one stage per iteration. One request is taken every
// cycle unless result_stall backs up a full pipeline. Three stages form the
// angle, one per CORDIC iteration, five scale the result. Amplitude (Q4.12),
// angular rate (Q8.8) and start phase (turn fraction) sit on the APB port at
// byte offsets 0, 4 and 8; write them only while no request is in flight.
module harmonic_motion_evaluator #(
    parameter int CORDIC_STEPS = hme_pkg::DEF_CORDIC_STEPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic [31:0]          sample_time,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic signed [16:0]   position,
    output logic signed [24:0]   speed,
    output logic signed [32:0]   accel,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [15:0]       amplitude_reg, rate_reg, phase_reg;
    logic [31:0]       amp_rate_reg, rate_sq_reg;
    logic              wr_en;
    logic              ang_valid, ang_stall, cor_valid, cor_stall;
    hme_pkg::cordic_t  ang_data, cor_data;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= hme_pkg::AMP_RESET;
            rate_reg <= hme_pkg::RATE_RESET;
            phase_reg <= hme_pkg::PHASE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                hme_pkg::REG_AMPLITUDE: amplitude_reg <= pwdata[15:0];
                hme_pkg::REG_RATE:      rate_reg <= pwdata[15:0];
                hme_pkg::REG_PHASE:     phase_reg <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    // derived scale factors follow the registers in the next cycle
    always_ff @(posedge clk)
    begin
        amp_rate_reg <= {16'b0, amplitude_reg} * {16'b0, rate_reg};
        rate_sq_reg <= {16'b0, rate_reg} * {16'b0, rate_reg};
    end

    always_comb
    begin
        case (paddr[3:2])
            hme_pkg::REG_AMPLITUDE: prdata = {16'b0, amplitude_reg};
            hme_pkg::REG_RATE:      prdata = {16'b0, rate_reg};
            hme_pkg::REG_PHASE:     prdata = {16'b0, phase_reg};
            default:                prdata = '0;
        endcase
    end

    hme_angle u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample_valid),
        .in_stall     (sample_stall),
        .sample_time  (sample_time),
        .angular_rate (rate_reg),
        .start_phase  (phase_reg),
        .out_valid    (ang_valid),
        .out_stall    (ang_stall),
        .out_data     (ang_data)
    );

    hme_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_stall  (ang_stall),
        .in_data   (ang_data),
        .out_valid (cor_valid),
        .out_stall (cor_stall),
        .out_data  (cor_data)
    );

    hme_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cor_valid),
        .in_stall  (cor_stall),
        .in_data   (cor_data),
        .amplitude (amplitude_reg),
        .amp_rate  (amp_rate_reg),
        .rate_sq   (rate_sq_reg),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .position  (position),
        .speed     (speed),
        .accel     (accel)
    );

    // input backs up only when every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("input stalled with room in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && paddr[3:2] == hme_pkg::REG_RATE) |=> rate_reg == $past(pwdata[15:0]))
        else $error("angular rate write lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && paddr[3:2] == hme_pkg::REG_AMPLITUDE)
        |-> prdata == {16'b0, amplitude_reg})
        else $error("amplitude readback mismatch");

endmodule

### bench/harmonic_motion_evaluator_tb.sv
`timescale 1ns / 1ps

module harmonic_motion_evaluator_tb;

    localparam int STEPS = hme_pkg::DEF_CORDIC_STEPS;
    localparam int LATENCY = ((STEPS > hme_pkg::TABLE_LEN) ? hme_pkg::TABLE_LEN : STEPS) + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic signed [16:0] pos;
        logic signed [24:0] spd;
        logic signed [32:0] acc;
    } motion_t;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    logic [31:0] sample_time;
    logic result_valid;
    logic result_stall;
    logic signed [16:0] position;
    logic signed [24:0] speed;
    logic signed [32:0] accel;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    logic [15:0] amp_cfg;
    logic [15:0] rate_cfg;
    logic [15:0] phase_cfg;

    motion_t expected_motion[$];
    int errors;
    int idle_cycles;
    int rx_gap_left;
    bit rx_idle_on;
    bit hold_off;
    bit tx_idle_on;

    harmonic_motion_evaluator dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_time(sample_time),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .position(position),
        .speed(speed),
        .accel(accel),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [127:0] round_shr(input logic signed [127:0] v,
                                                      input int s);
        logic signed [127:0] one;
        one = 128'sd1;
        return (v + (one <<< (s - 1))) >>> s;
    endfunction

    function automatic motion_t predict_motion(input logic [31:0] t);
        logic [63:0] prod;
        logic [127:0] turns;
        logic [31:0] angle;
        logic [31:0] a;
        logic flip;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [127:0] amp;
        logic signed [127:0] w;
        logic signed [127:0] amp_cos;
        motion_t m;
        int n;
        prod = 64'(rate_cfg) * 64'(t);
        turns = 128'(prod) * 128'(hme_pkg::RAD_TO_TURN);
        angle = turns[63:32] + {phase_cfg, 16'h0000};
        flip = angle[31] ^ angle[30];
        a = flip ? angle + 32'h80000000 : angle;
        z = 64'(signed'(a));
        x = 64'(hme_pkg::INV_GAIN_Q30);
        y = '0;
        n = (STEPS > hme_pkg::TABLE_LEN) ? hme_pkg::TABLE_LEN : STEPS;
        for (int i = 0; i < n; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - 64'(hme_pkg::atan_turn(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + 64'(hme_pkg::atan_turn(i));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        if (x > 64'(hme_pkg::ONE_Q30)) x = 64'(hme_pkg::ONE_Q30);
        if (x < -64'(hme_pkg::ONE_Q30)) x = -64'(hme_pkg::ONE_Q30);
        if (y > 64'(hme_pkg::ONE_Q30)) y = 64'(hme_pkg::ONE_Q30);
        if (y < -64'(hme_pkg::ONE_Q30)) y = -64'(hme_pkg::ONE_Q30);
        amp = 128'(amp_cfg);
        w = 128'(rate_cfg);
        m.pos = 17'(round_shr(amp * 128'(x), 30));
        m.spd = 25'(-round_shr(amp * w * 128'(y), 38));
        amp_cos = round_shr(amp * 128'(x), 18);
        m.acc = 33'(-round_shr(amp_cos * (w * w), 28));
        return m;
    endfunction

    // result checker and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        motion_t e;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_gap_left <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_motion.size() == 0)
                begin
                    $display("%0t: unexpected result pos=%0d spd=%0d acc=%0d",
                             $time, position, speed, accel);
                    errors++;
                end
                else
                begin
                    e = expected_motion.pop_front();
                    if (position !== e.pos)
                    begin
                        $display("%0t: position expected %0d actual %0d", $time, e.pos, position);
                        errors++;
                    end
                    if (speed !== e.spd)
                    begin
                        $display("%0t: speed expected %0d actual %0d", $time, e.spd, speed);
                        errors++;
                    end
                    if (accel !== e.acc)
                    begin
                        $display("%0t: accel expected %0d actual %0d", $time, e.acc, accel);
                        errors++;
                    end
                end
            end
            if (hold_off)
            begin
                result_stall <= 1'b1;
            end
            else if (rx_gap_left > 0)
            begin
                result_stall <= 1'b1;
                rx_gap_left <= rx_gap_left - 1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                // start a stalled burst; rx_gap_left holds the remaining stalled cycles
                result_stall <= 1'b1;
                rx_gap_left <= int'($urandom_range(0, 7));
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // watchdog on accepted handshakes
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            hme_pkg::REG_AMPLITUDE: amp_cfg = value[15:0];
            hme_pkg::REG_RATE: rate_cfg = value[15:0];
            hme_pkg::REG_PHASE: phase_cfg = value[15:0];
            default: ;
        endcase
    endtask

    task automatic record_expected(input motion_t m);
        expected_motion.insert(expected_motion.size(), m);
    endtask

    // hold valid across the edge; no gap is added when idling is off
    task automatic send_sample(input logic [31:0] t);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_time <= t;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        record_expected(predict_motion(t));
    endtask

    task automatic end_burst();
        sample_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_motion.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] a, input logic [15:0] w,
                              input logic [15:0] ph);
        drain();
        write_reg(hme_pkg::REG_AMPLITUDE, {16'hABCD, a});
        write_reg(hme_pkg::REG_RATE, {16'h1234, w});
        write_reg(hme_pkg::REG_PHASE, {16'hFFFF, ph});
        write_reg(REG_NONE, 32'hFFFFFFFF);
    endtask

    task automatic test_directed();
        logic [31:0] corner[$];
        corner = '{32'h0, 32'hFFFFFFFF, 32'h00010000, 32'h80000000, 32'h7FFFFFFF,
                   32'h00000001, 32'h0001921F, 32'h00032440, 32'h0004B65F, 32'h00006488};
        tx_idle_on = 0;
        foreach (corner[i]) send_sample(corner[i]);
        end_burst();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        foreach (corner[i]) send_sample(corner[i]);
        end_burst();
        set_config(16'h0000, 16'h0000, 16'h4000);
        foreach (corner[i]) send_sample(corner[i]);
        end_burst();
    endtask

    task automatic test_random_configs();
        tx_idle_on = 1;
        rx_idle_on = 1;
        for (int k = 0; k < 6; k++)
        begin
            set_config(16'($urandom), 16'($urandom), 16'($urandom));
            for (int i = 0; i < 150; i++)
                send_sample(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h40000) : $urandom);
            end_burst();
        end
    endtask

    task automatic test_backpressure();
        set_config(16'hFFFF, 16'hFFFF, 16'($urandom));
        hold_off = 1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 80; i++) send_sample($urandom);
            end
        join
        end_burst();
        drain();
        for (int i = 0; i < 40; i++) send_sample($urandom);
        end_burst();
    endtask

    task automatic test_streaming();
        set_config(16'($urandom), 16'($urandom_range(0, 300)), 16'($urandom));
        tx_idle_on = 0;
        rx_idle_on = 0;
        for (int i = 0; i < 300; i++) send_sample($urandom);
        end_burst();
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_time = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        idle_cycles = 0;
        rx_idle_on = 0;
        tx_idle_on = 0;
        hold_off = 0;
        amp_cfg = hme_pkg::AMP_RESET;
        rate_cfg = hme_pkg::RATE_RESET;
        phase_cfg = hme_pkg::PHASE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_configs();
        test_backpressure();
        test_streaming();
        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
design/hme_pkg.sv
design/hme_angle.sv
design/hme_cordic.sv
design/hme_scale.sv
design/harmonic_motion_evaluator.sv
bench/harmonic_motion_evaluator_tb.sv
